@@ src/msqrt_pkg.sv @@
// Package with payload types, sequencer states and operation codes for the modular square root.
`timescale 1ns / 1ps
package msqrt_pkg;

	// Input request payload.
	typedef struct packed {
		logic [31:0] n_value;
		logic [31:0] modulus;
	} msqrt_in_t;

	// Result payload.
	typedef struct packed {
		logic [31:0] root;
		logic        no_root;
	} msqrt_out_t;

	// Bound on the non-residue search.
	localparam logic [12:0] NONRES_LIMIT = 13'd4096;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_EULER_INIT,
		ST_POW_STEP,
		ST_POW_SQ,
		ST_EULER_CHECK,
		ST_FACTOR,
		ST_Z_INIT,
		ST_Z_CHECK,
		ST_C_INIT,
		ST_T_INIT,
		ST_R_INIT,
		ST_R_DONE,
		ST_LOOP_TEST,
		ST_SQ_T,
		ST_SQ_T_CHECK,
		ST_SQ_B,
		ST_UPD_C,
		ST_UPD_T,
		ST_UPD_R,
		ST_DONE
	} msqrt_state_t;

	// What a finished exponentiation feeds.
	typedef enum logic [2:0] {
		PW_EULER,
		PW_ROOT3,
		PW_ZTEST,
		PW_C,
		PW_T,
		PW_R
	} msqrt_pow_t;

	// Handshake between the sequencer and the multiplier.
	typedef struct packed {
		logic start;
	} msqrt_mul_req_t;

endpackage

@@ src/msqrt_mulmod.sv @@
// Shift-and-add modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module msqrt_mulmod
	import msqrt_pkg::*;
#(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  msqrt_mul_req_t req,
	input  logic [W-1:0] op_a,
	input  logic [W-1:0] op_b,
	input  logic [W-1:0] modv,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] prod
);

	logic [W-1:0] a_q, b_q, acc_q;
	logic         busy_q, done_q;
	logic [W:0]   sum_acc, sum_dbl;
	logic [W-1:0] acc_n, dbl_n;

	// Modular add of accumulator and addend, and doubling of the addend.
	always_comb begin
		sum_acc = {1'b0, acc_q} + {1'b0, a_q};
		sum_dbl = {1'b0, a_q} + {1'b0, a_q};
		acc_n = (sum_acc >= {1'b0, modv}) ? W'(sum_acc - {1'b0, modv}) : sum_acc[W-1:0];
		dbl_n = (sum_dbl >= {1'b0, modv}) ? W'(sum_dbl - {1'b0, modv}) : sum_dbl[W-1:0];
	end

	// One step per cycle until the multiplier bits are used up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && (b_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_n;
			end
			a_q <= dbl_n;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

`ifndef SYNTH
	// A start is never issued while a product is in progress.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("multiplier restarted while busy");
	// Done follows the end of a run only.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a run");
	// The accumulator stays reduced below the modulus.
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && modv != '0) |-> acc_q < modv)
		else $error("accumulator not reduced");
`endif

endmodule

@@ src/msqrt_seq.sv @@
// Sequencer that runs the residue test, exponentiations and the Tonelli-Shanks loop.
`timescale 1ns / 1ps
module msqrt_seq
	import msqrt_pkg::*;
#(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] n_in,
	input  logic [W-1:0] p_in,
	output logic         busy,
	output logic         fin,
	output logic [W-1:0] root,
	output logic         no_root
);

	localparam int SW = $clog2(W + 1);
	localparam int ZW = W + 13;

	msqrt_state_t state_q, state_n;
	msqrt_pow_t   pk_q;
	logic [W-1:0] p_q, a_q, q_q, z_q, c_q, t_q, r_q, b_q, tt_q;
	logic [W-1:0] pacc_q, pbase_q, pexp_q, res_q;
	logic [SW-1:0] s_q, m_q, i_q, j_q;
	logic         nr_q, busy_q, fin_q;
	logic [W-1:0] mop_a, mop_b, mprod;
	logic         mbusy, mdone;
	msqrt_mul_req_t mreq;
	logic [W-1:0] zlim;
	logic [W:0]   rem_sub;
	logic [W-1:0] rem_q, rdiv_q;
	logic [SW-1:0] rcnt_q;
	logic         go_q;
	logic         mul_idle, mul_go, triv, sq_loop_go, sqb_end, z_fail;

	msqrt_mulmod #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .op_a(mop_a), .op_b(mop_b),
		.modv(p_q), .busy(mbusy), .done(mdone), .prod(mprod)
	);

	// Search bound: the smaller of p-1 and the fixed limit.
	always_comb begin
		if (ZW'(p_q - 1'b1) > ZW'(NONRES_LIMIT)) zlim = W'(NONRES_LIMIT);
		else zlim = p_q - 1'b1;
	end

	// Restoring remainder step for n mod p.
	assign rem_sub = {rem_q, rdiv_q[W-1]} - {1'b0, p_q};

	// Conditions shared by the next-state and datapath logic.
	assign mul_idle   = !mbusy && !mreq.start && !mdone;
	assign triv       = (n_in == '0) || (p_in < W'(3)) || !p_in[0];
	assign sq_loop_go = (tt_q != W'(1)) && (i_q < m_q);
	assign sqb_end    = ((SW+1)'(j_q) + (SW+1)'(i_q) + 1'b1) >= (SW+1)'(m_q);
	assign z_fail     = z_q > zlim;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_n = triv ? ST_DONE : ST_REDUCE;
			end
			ST_REDUCE: begin
				if (go_q && rcnt_q == '0) state_n = (rem_q == '0) ? ST_DONE : ST_EULER_INIT;
			end
			ST_EULER_INIT:  state_n = ST_POW_STEP;
			ST_POW_STEP: begin
				if (mul_idle) begin
					if (pexp_q == '0) begin
						unique case (pk_q)
							PW_EULER: state_n = ST_EULER_CHECK;
							PW_ROOT3: state_n = ST_DONE;
							PW_ZTEST: state_n = ST_Z_CHECK;
							PW_C:     state_n = ST_T_INIT;
							PW_T:     state_n = ST_R_INIT;
							PW_R:     state_n = ST_R_DONE;
							default:  state_n = ST_DONE;
						endcase
					end else if (!pexp_q[0]) begin
						state_n = ST_POW_SQ;
					end
				end else if (mdone) begin
					state_n = ST_POW_SQ;
				end
			end
			ST_POW_SQ:      if (mdone) state_n = ST_POW_STEP;
			ST_EULER_CHECK: begin
				if (pacc_q != W'(1)) state_n = ST_DONE;
				else if (p_q[1:0] == 2'b11) state_n = ST_POW_STEP;
				else state_n = ST_FACTOR;
			end
			ST_FACTOR:      if (q_q[0]) state_n = ST_Z_INIT;
			ST_Z_INIT:      state_n = z_fail ? ST_DONE : ST_POW_STEP;
			ST_Z_CHECK:     state_n = (pacc_q == p_q - 1'b1) ? ST_C_INIT : ST_Z_INIT;
			ST_C_INIT:      state_n = ST_POW_STEP;
			ST_T_INIT:      state_n = ST_POW_STEP;
			ST_R_INIT:      state_n = ST_POW_STEP;
			ST_R_DONE:      state_n = ST_LOOP_TEST;
			ST_LOOP_TEST:   state_n = (t_q == W'(1)) ? ST_DONE : ST_SQ_T_CHECK;
			ST_SQ_T_CHECK: begin
				if (sq_loop_go) state_n = ST_SQ_T;
				else if (tt_q != W'(1) || i_q >= m_q) state_n = ST_DONE;
				else state_n = ST_SQ_B;
			end
			ST_SQ_T:        if (mdone) state_n = ST_SQ_T_CHECK;
			ST_SQ_B:        if (sqb_end) state_n = ST_UPD_C;
			ST_UPD_C:       if (mdone) state_n = ST_UPD_T;
			ST_UPD_T:       if (mdone) state_n = ST_UPD_R;
			ST_UPD_R:       if (mdone) state_n = ST_LOOP_TEST;
			ST_DONE:        state_n = ST_IDLE;
			default:        state_n = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer, including the multiplier start request.
	always_comb begin
		busy    = busy_q;
		fin     = fin_q;
		root    = res_q;
		no_root = nr_q;
		mul_go  = 1'b0;
		if (mul_idle) begin
			unique case (state_q) inside
				ST_POW_STEP: mul_go = (pexp_q != '0) && pexp_q[0];
				ST_POW_SQ, ST_SQ_T, ST_UPD_C, ST_UPD_T, ST_UPD_R: mul_go = 1'b1;
				ST_SQ_B: mul_go = !sqb_end;
				default: mul_go = 1'b0;
			endcase
		end
	end

	// State register and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			go_q    <= 1'b0;
			mreq    <= '0;
		end else begin
			state_q    <= state_n;
			fin_q      <= (state_q == ST_DONE);
			go_q       <= (state_q == ST_REDUCE);
			mreq.start <= mul_go;
			if (state_q == ST_IDLE && start) begin
				busy_q <= 1'b1;
			end else if (state_q == ST_DONE) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath registers, loaded according to the current state.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					a_q <= n_in;
					p_q <= p_in;
					if (n_in == '0) begin
						res_q <= '0; nr_q <= 1'b0;
					end else if (p_in < W'(2)) begin
						res_q <= '0; nr_q <= 1'b1;
					end else if (p_in == W'(2)) begin
						res_q <= W'(n_in[0]); nr_q <= 1'b0;
					end else if (!p_in[0]) begin
						res_q <= '0; nr_q <= 1'b1;
					end
				end
			end
			ST_REDUCE: begin
				if (!go_q) begin
					rcnt_q <= SW'(W);
					rem_q <= '0;
					rdiv_q <= a_q;
				end else if (rcnt_q != '0) begin
					rcnt_q <= rcnt_q - 1'b1;
					rdiv_q <= rdiv_q << 1;
					if (!rem_sub[W]) rem_q <= rem_sub[W-1:0];
					else rem_q <= {rem_q[W-2:0], rdiv_q[W-1]};
				end else begin
					a_q <= rem_q;
					if (rem_q == '0) begin
						res_q <= '0; nr_q <= 1'b1;
					end
				end
			end
			ST_EULER_INIT: begin
				pk_q <= PW_EULER; pacc_q <= W'(1); pbase_q <= a_q;
				pexp_q <= p_q >> 1;
			end
			ST_POW_STEP: begin
				// Multiply accumulator by base when the exponent bit is set.
				if (mul_idle) begin
					if (pexp_q == '0) begin
						unique case (pk_q) inside
							PW_ROOT3: begin res_q <= pacc_q; nr_q <= 1'b0; end
							PW_C: c_q <= pacc_q;
							PW_T: t_q <= pacc_q;
							PW_R: r_q <= pacc_q;
							PW_EULER, PW_ZTEST: ;
							default: begin res_q <= '0; nr_q <= 1'b1; end
						endcase
					end else if (pexp_q[0]) begin
						mop_a <= pacc_q; mop_b <= pbase_q;
					end
				end else if (mdone) begin
					pacc_q <= mprod;
				end
			end
			ST_POW_SQ: begin
				if (mul_idle) begin
					mop_a <= pbase_q; mop_b <= pbase_q;
				end else if (mdone) begin
					pbase_q <= mprod;
					pexp_q <= pexp_q >> 1;
				end
			end
			ST_EULER_CHECK: begin
				if (pacc_q != W'(1)) begin
					res_q <= '0; nr_q <= 1'b1;
				end else if (p_q[1:0] == 2'b11) begin
					pk_q <= PW_ROOT3; pacc_q <= W'(1); pbase_q <= a_q;
					pexp_q <= (p_q >> 2) + 1'b1;
				end else begin
					q_q <= p_q - 1'b1; s_q <= '0;
				end
			end
			ST_FACTOR: begin
				if (!q_q[0]) begin
					q_q <= q_q >> 1; s_q <= s_q + 1'b1;
				end else begin
					z_q <= W'(2);
				end
			end
			ST_Z_INIT: begin
				if (z_fail) begin
					res_q <= '0; nr_q <= 1'b1;
				end else begin
					pk_q <= PW_ZTEST; pacc_q <= W'(1); pbase_q <= z_q;
					pexp_q <= p_q >> 1;
				end
			end
			ST_Z_CHECK: begin
				if (pacc_q == p_q - 1'b1) m_q <= s_q;
				else z_q <= z_q + 1'b1;
			end
			ST_C_INIT: begin
				pk_q <= PW_C; pacc_q <= W'(1); pbase_q <= z_q; pexp_q <= q_q;
			end
			ST_T_INIT: begin
				pk_q <= PW_T; pacc_q <= W'(1); pbase_q <= a_q; pexp_q <= q_q;
			end
			ST_R_INIT: begin
				pk_q <= PW_R; pacc_q <= W'(1); pbase_q <= a_q;
				pexp_q <= (q_q >> 1) + 1'b1;
			end
			ST_LOOP_TEST: begin
				if (t_q == W'(1)) begin
					res_q <= r_q; nr_q <= 1'b0;
				end else begin
					tt_q <= t_q; i_q <= '0;
				end
			end
			ST_SQ_T_CHECK: begin
				if (!sq_loop_go) begin
					if (tt_q != W'(1) || i_q >= m_q) begin
						res_q <= '0; nr_q <= 1'b1;
					end else begin
						b_q <= c_q; j_q <= '0;
					end
				end
			end
			ST_SQ_T: begin
				if (mul_idle) begin
					mop_a <= tt_q; mop_b <= tt_q;
				end else if (mdone) begin
					tt_q <= mprod; i_q <= i_q + 1'b1;
				end
			end
			ST_SQ_B: begin
				if (sqb_end) begin
					m_q <= i_q;
				end else if (mul_idle) begin
					mop_a <= b_q; mop_b <= b_q;
				end else if (mdone) begin
					b_q <= mprod; j_q <= j_q + 1'b1;
				end
			end
			ST_UPD_C: begin
				if (mul_idle) begin
					mop_a <= b_q; mop_b <= b_q;
				end else if (mdone) begin
					c_q <= mprod;
				end
			end
			ST_UPD_T: begin
				if (mul_idle) begin
					mop_a <= t_q; mop_b <= c_q;
				end else if (mdone) begin
					t_q <= mprod;
				end
			end
			ST_UPD_R: begin
				if (mul_idle) begin
					mop_a <= r_q; mop_b <= b_q;
				end else if (mdone) begin
					r_q <= mprod;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// Busy covers every state other than idle.
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> busy_q) else $error("busy dropped mid-request");
	// A finish pulse comes only from the done state.
	a_fin_src: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> $past(state_q) == ST_DONE) else $error("stray finish");
	// A result with the no-root flag always carries a zero root.
	a_nr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && nr_q) |-> res_q == '0) else $error("root set with no_root");
`endif

endmodule

@@ src/modular_square_root.sv @@
// Top level of the modular square root block with its request and result registers.
`timescale 1ns / 1ps
// Modular square root by Tonelli-Shanks.
// Input channel in_req/in_valid/in_stall carries n_value and a prime modulus;
// output channel out_res/out_valid/out_stall carries root and no_root.
// One request is worked at a time: in_stall is high from acceptance until
// the result has been moved into the output register, so the next request
// is taken at the earliest in the cycle in which out_valid rises.
// Every product runs on one shift-and-add modular multiplier. An
// exponentiation takes one squaring per exponent bit and one more product
// per set bit, and the non-residue search needs one exponentiation for
// each candidate. Zero values, moduli below three and even moduli skip the
// reduction of n mod p and go straight to the done state.
// While out_stall holds a result in the output register, a newly finished
// result waits in a holding register and in_stall stays high until it moves.
// Reset clears the sequencer, the holding flag and the output valid; no
// clearing pass is needed.
module modular_square_root
	import msqrt_pkg::*;
#(
	parameter int MOD_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  msqrt_in_t  in_req,
	input  logic       in_valid,
	output logic       in_stall,
	output msqrt_out_t out_res,
	output logic       out_valid,
	input  logic       out_stall
);

	localparam int W = MOD_WIDTH;

	logic         seq_busy, seq_fin, seq_nr, start, load_out;
	logic [W-1:0] seq_root, n_w, p_w;
	logic         hold_q, out_valid_q;
	msqrt_out_t   hold_res_q, out_res_q;

	// Operands are cut to the datapath width.
	always_comb begin
		n_w = W'(in_req.n_value);
		p_w = W'(in_req.modulus);
	end

	assign in_stall = seq_busy || hold_q || seq_fin;
	assign start    = in_valid && !in_stall;
	assign load_out = (hold_q || seq_fin) && (!out_valid_q || !out_stall);

	msqrt_seq #(.W(W)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .n_in(n_w), .p_in(p_w),
		.busy(seq_busy), .fin(seq_fin), .root(seq_root), .no_root(seq_nr)
	);

	// Result holding register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				hold_q <= 1'b0;
			end else if (seq_fin) begin
				hold_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_fin) begin
			hold_res_q.root    <= 32'(seq_root);
			hold_res_q.no_root <= seq_nr;
		end
		if (load_out) begin
			if (seq_fin) begin
				out_res_q.root    <= 32'(seq_root);
				out_res_q.no_root <= seq_nr;
			end else begin
				out_res_q <= hold_res_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

`ifndef SYNTH
	// A request is never taken while the sequencer is working.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seq_busy |-> in_stall) else $error("request taken while busy");
	// The holding register is only filled by a finish.
	a_hold_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hold_q) |-> $past(seq_fin)) else $error("hold filled without finish");
	// A finish never arrives while a result is still held.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		seq_fin |-> !hold_q) else $error("result overrun");
`endif

endmodule

@@ tb/tb_modular_square_root.sv @@
// Self-checking testbench for the modular square root block.
`timescale 1ns / 1ps
module tb_modular_square_root;
	import msqrt_pkg::*;

	logic       clk;
	logic       arst_n;
	msqrt_in_t  in_req;
	logic       in_valid;
	logic       in_stall;
	msqrt_out_t out_res;
	logic       out_valid;
	logic       out_stall;

	msqrt_out_t root_queue[$];
	int         err_count;
	int         send_idle_pct;
	int         stall_pct;
	int         n_sent;
	int         n_checked;

	modular_square_root #(.MOD_WIDTH(32)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_req   (in_req),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_res  (out_res),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard limit on the run.
	initial begin
		#1_000_000_000;
		$display("Verification failed");
		$finish;
	end

	// Modular arithmetic on 32-bit operands; products fit in 64 bits.
	function automatic bit [63:0] mulm(bit [63:0] a, bit [63:0] b, bit [63:0] m);
		return (a * b) % m;
	endfunction

	function automatic bit [63:0] powm(bit [63:0] base, bit [63:0] e, bit [63:0] m);
		bit [63:0] acc;
		acc = 1 % m;
		base = base % m;
		while (e != 0) begin
			if (e[0])
				acc = mulm(acc, base, m);
			base = mulm(base, base, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// Predicts the result of one request by Tonelli-Shanks.
	function automatic msqrt_out_t predict_root(bit [31:0] nv, bit [31:0] pv);
		msqrt_out_t res;
		bit [63:0]  n, p, a, q, z, zlim, c, t, r, tt, b;
		int         s, m, i, j;
		n = nv;
		p = pv;
		res.root = '0;
		res.no_root = 1'b1;
		if (n == 0) begin
			res.no_root = 1'b0;
			return res;
		end
		if (p < 2)
			return res;
		if (p == 2) begin
			res.root = {31'd0, nv[0]};
			res.no_root = 1'b0;
			return res;
		end
		if (p[0] == 1'b0)
			return res;
		a = n % p;
		if (a == 0)
			return res;
		if (powm(a, p >> 1, p) != 1)
			return res;
		if (p[1:0] == 2'b11) begin
			res.root = 32'(powm(a, (p >> 2) + 1, p));
			res.no_root = 1'b0;
			return res;
		end
		q = p - 1;
		s = 0;
		while (q[0] == 1'b0) begin
			q = q >> 1;
			s++;
		end
		zlim = p - 1;
		if (zlim > NONRES_LIMIT)
			zlim = NONRES_LIMIT;
		for (z = 2; z <= zlim; z++) begin
			if (powm(z, p >> 1, p) == p - 1)
				break;
		end
		if (z > zlim)
			return res;
		m = s;
		c = powm(z, q, p);
		t = powm(a, q, p);
		r = powm(a, (q >> 1) + 1, p);
		while (t != 1) begin
			tt = t;
			i = 0;
			while (tt != 1 && i < m) begin
				tt = mulm(tt, tt, p);
				i++;
			end
			if (tt != 1 || i >= m)
				return res;
			b = c;
			for (j = 0; j + i + 1 < m; j++)
				b = mulm(b, b, p);
			m = i;
			c = mulm(b, b, p);
			t = mulm(t, c, p);
			r = mulm(r, b, p);
		end
		res.root = 32'(r);
		res.no_root = 1'b0;
		return res;
	endfunction

	function automatic bit is_prime(bit [31:0] x);
		bit [63:0] d;
		if (x < 2)
			return 1'b0;
		if (x < 4)
			return 1'b1;
		if (x[0] == 1'b0)
			return 1'b0;
		for (d = 3; d * d <= x; d += 2)
			if (x % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// Random odd prime with the top bit of the given width set.
	function automatic bit [31:0] rand_prime(int bits);
		bit [31:0] x;
		do begin
			x = $urandom;
			if (bits < 32)
				x = x & ((32'd1 << bits) - 1);
			x[bits-1] = 1'b1;
			x[0] = 1'b1;
		end while (!is_prime(x));
		return x;
	endfunction

	// Record each accepted request's expected result.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			root_queue.push_back(predict_root(in_req.n_value, in_req.modulus));
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		msqrt_out_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (root_queue.size() == 0) begin
				$display("%0t: unexpected result root=%h no_root=%b",
					$time, out_res.root, out_res.no_root);
				err_count++;
			end else begin
				exp_res = root_queue.pop_front();
				if (out_res.root !== exp_res.root) begin
					$display("%0t: root expected %h actual %h",
						$time, exp_res.root, out_res.root);
					err_count++;
				end
				if (out_res.no_root !== exp_res.no_root) begin
					$display("%0t: no_root expected %b actual %b",
						$time, exp_res.no_root, out_res.no_root);
					err_count++;
				end
			end
		end
	end

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Sends one request and waits for it to be accepted.
	task automatic send_req(bit [31:0] nv, bit [31:0] pv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_req.n_value <= nv;
		in_req.modulus <= pv;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		n_sent++;
	endtask

	task automatic test_directed();
		send_req(32'd0, 32'd7);
		send_req(32'd0, 32'd0);
		send_req(32'hFFFFFFFF, 32'd2);
		send_req(32'd6, 32'd2);
		send_req(32'd5, 32'd0);
		send_req(32'd5, 32'd1);
		send_req(32'd5, 32'd4);
		send_req(32'hFFFFFFFF, 32'hFFFFFFFE);
		send_req(32'd14, 32'd7);
		send_req(32'd2, 32'd7);
		send_req(32'd3, 32'd7);
		send_req(32'd4, 32'd13);
		send_req(32'd5, 32'd13);
		send_req(32'd2, 32'd17);
		send_req(32'd3, 32'd65537);
		send_req(32'd2, 32'd65537);
		send_req(32'd5, 32'd3221225473);
		send_req(32'd9, 32'd3221225473);
		send_req(32'hFFFFFFFF, 32'd4294967291);
		send_req(32'd4, 32'd4294967291);
		send_req(32'd7, 32'd9);
		send_req(32'd4, 32'd25);
		send_req(32'd16, 32'd45);
		send_req(32'd1, 32'd21);
	endtask

	// Mostly primes with squares for values so the full loop runs often.
	task automatic test_random(int count);
		bit [31:0] p, x, nv;
		int        kind;
		for (int k = 0; k < count; k++) begin
			kind = $urandom_range(99);
			if (kind < 10)
				p = (32'd1 << ($urandom_range(6) + 3)) * 32'($urandom_range(6) * 2 + 1);
			else if (kind < 20) begin
				case ($urandom_range(4))
					0: p = 32'd9;
					1: p = 32'd15;
					2: p = 32'd25;
					3: p = 32'd45;
					default: p = 32'd2;
				endcase
			end else if (kind < 35)
				p = rand_prime(32);
			else
				p = rand_prime($urandom_range(28, 4));
			x = $urandom;
			if ($urandom_range(99) < 60 && p != 0) begin
				nv = 32'(mulm(x % p, x % p, p));
				if ($urandom_range(3) == 0)
					nv = nv + p * ($urandom / p);
			end else
				nv = x;
			send_req(nv, p);
		end
	endtask

	initial begin
		err_count = 0;
		n_sent = 0;
		n_checked = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		in_valid <= 1'b0;
		in_req <= '0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_random(32);
		send_idle_pct = 51;
		test_random(32);
		send_idle_pct = 0;
		stall_pct = 51;
		test_random(32);
		send_idle_pct = 33;
		stall_pct = 33;
		test_random(30);
		in_valid <= 1'b0;
		while (n_checked < n_sent)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (err_count == 0 && root_queue.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
